[hw/rtl/rdla_pkg.sv]
// Package for the RMS decibel level alarm: shared types, register codes,
// arithmetic constants and the tenth-decade coefficient table.
// No dependencies; every other RTL file imports it.
`default_nettype none

package rdla_pkg;

  // Field and datapath widths.
  localparam int SAMPLE_W = 16;
  localparam int ENERGY_W = 47;
  localparam int COUNT_W  = 16;
  localparam int POWER_W  = 46;
  localparam int SCALE_W  = 50;
  localparam int LIMIT_W  = 76;
  localparam int PROD_W   = 84;
  localparam int MUL_A_W  = 25;
  localparam int MUL_B_W  = 33;
  localparam int STEP_W   = 8;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [7:0]          level_t;

  // Register map, one 32-bit word per register.
  typedef enum logic [1:0] {
    REG_BLOCK_LENGTH    = 2'd0,
    REG_LEVEL_OFFSET    = 2'd1,
    REG_UPPER_THRESHOLD = 2'd2,
    REG_LOWER_THRESHOLD = 2'd3
  } reg_idx_t;

  localparam logic [15:0]        RST_BLOCK_LENGTH    = 16'd9600;
  localparam logic [6:0]         RST_LEVEL_OFFSET    = 7'd72;
  localparam logic signed [7:0]  RST_UPPER_THRESHOLD = 8'sd60;
  localparam logic signed [7:0]  RST_LOWER_THRESHOLD = 8'sd0;

  typedef struct packed {
    logic [15:0]       block_length;
    logic [6:0]        level_offset;
    logic signed [7:0] upper_threshold;
    logic signed [7:0] lower_threshold;
  } cfg_t;

  // Level limits, in the 9-bit signed form used before saturation.
  localparam logic signed [8:0] LEVEL_FLOOR = -9'sd64;
  localparam logic signed [8:0] LEVEL_CEIL  = 9'sd80;

  // Full scale squared, and full scale squared times 10^9 split in halves.
  localparam logic [29:0] FULL_SCALE_SQ = 30'd1073676289;
  localparam logic [59:0] FULL_SCALE_DEC = 60'd1073676289000000000;
  localparam logic [29:0] FS_DEC_LO = FULL_SCALE_DEC[29:0];
  localparam logic [29:0] FS_DEC_HI = FULL_SCALE_DEC[59:30];

  // Tenth-decade digit at which the decade multiplier steps up.
  localparam logic [3:0] LAST_DIGIT = 4'd9;

  // Operation selected for the shared multiplier.
  typedef enum logic [2:0] {
    MOP_NONE = 3'd0,
    MOP_P    = 3'd1,
    MOP_P9LO = 3'd2,
    MOP_P9HI = 3'd3,
    MOP_CLO  = 3'd4,
    MOP_CHI  = 3'd5
  } mul_op_t;

  typedef enum logic [2:0] {
    ST_ACCUM = 3'd0,
    ST_PMUL  = 3'd1,
    ST_P9LO  = 3'd2,
    ST_P9HI  = 3'd3,
    ST_CLO   = 3'd4,
    ST_CHI   = 3'd5,
    ST_CMP   = 3'd6,
    ST_DONE  = 3'd7
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;
    logic    step;
    logic    load_out;
    mul_op_t op;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
    logic zero;
    logic over;
    logic fit;
    logic limit;
    logic out_busy;
  } dp_status_t;

  // 10^(r/10) scaled by 10^9, rounded to nearest.
  function automatic logic [MUL_B_W-1:0] tenth_pow(input logic [3:0] r);
    logic [MUL_B_W-1:0] c;
    case (r)
      4'd0:    c = 33'd1000000000;
      4'd1:    c = 33'd1258925412;
      4'd2:    c = 33'd1584893192;
      4'd3:    c = 33'd1995262315;
      4'd4:    c = 33'd2511886432;
      4'd5:    c = 33'd3162277660;
      4'd6:    c = 33'd3981071706;
      4'd7:    c = 33'd5011872336;
      4'd8:    c = 33'd6309573445;
      4'd9:    c = 33'd7943282347;
      default: c = 33'd1000000000;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/rdla_sample_if.sv]
// Stream interface that carries one audio sample per transfer.
// Depends on rdla_pkg for the sample type.
`default_nettype none

interface rdla_sample_if import rdla_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

[hw/rtl/rdla_level_if.sv]
// Stream interface that carries one block level result per transfer.
// Depends on rdla_pkg for the level type.
`default_nettype none

interface rdla_level_if import rdla_pkg::*; ();
  logic   valid;
  logic   ready;
  level_t level_db;
  logic   alarm;
  logic   silent;

  modport source (output valid, output level_db, output alarm, output silent, input ready);
  modport sink (input valid, input level_db, input alarm, input silent, output ready);
endinterface

`default_nettype wire

[hw/rtl/rdla_regs.sv]
// APB-style configuration registers of the level meter.
// Depends on rdla_pkg for the register map and reset values.
`default_nettype none

module rdla_regs import rdla_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_length    <= RST_BLOCK_LENGTH;
      cfg.level_offset    <= RST_LEVEL_OFFSET;
      cfg.upper_threshold <= RST_UPPER_THRESHOLD;
      cfg.lower_threshold <= RST_LOWER_THRESHOLD;
    end else if (wr_en) begin
      unique case (idx)
        REG_BLOCK_LENGTH:    cfg.block_length    <= pwdata[15:0];
        REG_LEVEL_OFFSET:    cfg.level_offset    <= pwdata[6:0];
        REG_UPPER_THRESHOLD: cfg.upper_threshold <= pwdata[7:0];
        REG_LOWER_THRESHOLD: cfg.lower_threshold <= pwdata[7:0];
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    unique case (idx)
      REG_BLOCK_LENGTH:    prdata = {16'b0, cfg.block_length};
      REG_LEVEL_OFFSET:    prdata = {25'b0, cfg.level_offset};
      REG_UPPER_THRESHOLD: prdata = {24'b0, cfg.upper_threshold};
      REG_LOWER_THRESHOLD: prdata = {24'b0, cfg.lower_threshold};
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/rdla_ctrl.sv]
// Controller of the level meter: sequences accumulation, the power
// products and the dB search. Depends on rdla_pkg for commands and status.
`default_nettype none

module rdla_ctrl import rdla_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.step     = 1'b0;
    cmd.load_out = 1'b0;
    cmd.op       = MOP_NONE;
    unique case (state)
      ST_ACCUM: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && status.last) begin
          state_next = ST_PMUL;
        end
      end
      ST_PMUL: begin
        cmd.op     = MOP_P;
        state_next = ST_P9LO;
      end
      ST_P9LO: begin
        cmd.op     = MOP_P9LO;
        state_next = ST_P9HI;
      end
      ST_P9HI: begin
        cmd.op = MOP_P9HI;
        // Silent and over-full-scale blocks need no search.
        if (status.zero || status.over) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_CLO;
        end
      end
      ST_CLO: begin
        cmd.op     = MOP_CLO;
        state_next = ST_CHI;
      end
      ST_CHI: begin
        cmd.op     = MOP_CHI;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        cmd.step = 1'b1;
        if (!status.fit || status.limit) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_CLO;
        end
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_ACCUM;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/rdla_dp.sv]
// Datapath of the level meter: energy accumulator, shared multiplier,
// dB search registers and the result register. Depends on rdla_pkg.
`default_nettype none

module rdla_dp import rdla_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  ctrl_cmd_t  cmd,
  input  cfg_t       cfg,
  input  sample_t    sample,
  input  logic       out_ready,
  output dp_status_t status,
  output logic       out_valid,
  output level_t     level_db,
  output logic       alarm,
  output logic       silent
);

  logic [ENERGY_W-1:0] energy;
  logic [COUNT_W-1:0]  seen;
  logic [ENERGY_W-1:0] sreg;
  logic [COUNT_W-1:0]  nreg;
  logic [POWER_W-1:0]  preg;
  logic [LIMIT_W-1:0]  p9;
  logic [PROD_W-1:0]   acc;
  logic [SCALE_W-1:0]  sq;
  logic [STEP_W-1:0]   m;
  logic [3:0]          r;

  logic [COUNT_W-1:0]  len;
  logic [COUNT_W:0]    count;
  logic signed [31:0]  sample_sq;
  logic [ENERGY_W-1:0] energy_next;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [MUL_A_W+MUL_B_W-1:0] prod;
  logic [STEP_W-1:0]   m_inc;
  logic [STEP_W-1:0]   m_stop;
  logic signed [8:0]   d_raw;
  logic signed [8:0]   d_sat;
  level_t              level_next;

  // Block length zero behaves as one.
  assign len   = (cfg.block_length == '0) ? COUNT_W'(1) : cfg.block_length;
  assign count = {1'b0, seen} + (COUNT_W+1)'(1);

  // Square of the incoming sample added to the running energy.
  assign sample_sq   = sample * sample;
  assign energy_next = energy + {{(ENERGY_W-31){1'b0}}, sample_sq[30:0]};

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      MOP_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      MOP_P: begin
        mul_a = {{(MUL_A_W-COUNT_W){1'b0}}, nreg};
        mul_b = {3'b0, FULL_SCALE_SQ};
      end
      MOP_P9LO: begin
        mul_a = {{(MUL_A_W-COUNT_W){1'b0}}, nreg};
        mul_b = {3'b0, FS_DEC_LO};
      end
      MOP_P9HI: begin
        mul_a = {{(MUL_A_W-COUNT_W){1'b0}}, nreg};
        mul_b = {3'b0, FS_DEC_HI};
      end
      MOP_CLO: begin
        mul_a = sq[MUL_A_W-1:0];
        mul_b = tenth_pow(r);
      end
      MOP_CHI: begin
        mul_a = sq[SCALE_W-1:MUL_A_W];
        mul_b = tenth_pow(r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Search bounds: stop once the level would reach the floor.
  assign m_inc  = m + STEP_W'(1);
  assign m_stop = {1'b0, cfg.level_offset} + STEP_W'(64);

  assign status.last     = (count >= {1'b0, len});
  assign status.zero     = (sreg == '0);
  assign status.over     = ({1'b0, sreg} > {2'b0, preg});
  assign status.fit      = (acc <= {{(PROD_W-LIMIT_W){1'b0}}, p9});
  assign status.limit    = (m_inc >= m_stop);
  assign status.out_busy = out_valid && !out_ready;

  // Level from the search result, then saturation and threshold compare.
  always_comb begin
    if (status.zero) begin
      d_raw = LEVEL_FLOOR;
    end else if (status.over) begin
      d_raw = $signed({2'b0, cfg.level_offset}) + 9'sd1;
    end else begin
      d_raw = $signed({2'b0, cfg.level_offset} - {1'b0, m});
    end
    if (d_raw > LEVEL_CEIL) begin
      d_sat = LEVEL_CEIL;
    end else if (d_raw < LEVEL_FLOOR) begin
      d_sat = LEVEL_FLOOR;
    end else begin
      d_sat = d_raw;
    end
  end

  assign level_next = d_sat[7:0];

  // Accumulator and sample counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      energy <= '0;
      seen   <= '0;
    end else if (cmd.accept) begin
      if (status.last) begin
        energy <= '0;
        seen   <= '0;
      end else begin
        energy <= energy_next;
        seen   <= count[COUNT_W-1:0];
      end
    end
  end

  // Block capture, power products and the search registers.
  always_ff @(posedge clk) begin
    if (cmd.accept && status.last) begin
      sreg <= energy_next;
      nreg <= count[COUNT_W-1:0];
      sq   <= {{(SCALE_W-ENERGY_W){1'b0}}, energy_next};
      m    <= '0;
      r    <= 4'd1;
    end else if (cmd.step && status.fit) begin
      m <= m_inc;
      if (r == LAST_DIGIT) begin
        r  <= '0;
        sq <= (sq << 3) + (sq << 1);
      end else begin
        r <= r + 4'd1;
      end
    end
    case (cmd.op)
      MOP_P:    preg <= prod[POWER_W-1:0];
      MOP_P9LO: acc  <= {{(PROD_W-MUL_A_W-MUL_B_W){1'b0}}, prod};
      MOP_P9HI: p9   <= acc[LIMIT_W-1:0] + {prod[POWER_W-1:0], 30'b0};
      MOP_CLO:  acc  <= {{(PROD_W-MUL_A_W-MUL_B_W){1'b0}}, prod};
      MOP_CHI:  acc  <= acc + {1'b0, prod, {MUL_A_W{1'b0}}};
      default:  acc  <= acc;
    endcase
  end

  // Output register; a new result loads once the previous one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      level_db <= level_next;
      silent   <= status.zero;
      alarm    <= ($signed(level_next) >= cfg.upper_threshold) ||
                  ($signed(level_next) <= cfg.lower_threshold);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rms_decibel_level_alarm.sv]
// Block RMS sound level meter with a high and low level alarm: the top level.
// Depends on rdla_pkg, the two stream interfaces, rdla_regs, rdla_ctrl and rdla_dp.
//
// Samples are taken one per clock cycle while a block fills; the squares are
// summed in a 47-bit accumulator. The sample that completes a block starts the
// level computation, during which no sample is accepted: the states ST_PMUL,
// ST_P9LO and ST_P9HI form the block power and its 10^9-scaled copy on a shared
// multiplier, then each dB step below the offset takes two partial products
// and a compare, for at most level_offset+64 steps, and the ST_DONE state loads
// the result register. Silent blocks and blocks above full scale skip the
// search. The load also waits for as long as the previous result is still
// stalled in the output register. A result waits in the output register
// while the next block accumulates.
`default_nettype none

module rms_decibel_level_alarm import rdla_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  rdla_sample_if.sink       audio,
  rdla_level_if.source      level
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Configuration registers.
  rdla_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer.
  rdla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (audio.valid),
    .in_ready (audio.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and result register.
  rdla_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg),
    .sample    (audio.sample),
    .out_ready (level.ready),
    .status    (status),
    .out_valid (level.valid),
    .level_db  (level.level_db),
    .alarm     (level.alarm),
    .silent    (level.silent)
  );

endmodule

`default_nettype wire

[hw/rtl/rdla_checker.sv]
// Port-level checks for the level meter, and the bind that attaches them.
// Depends on rdla_pkg and on the top level rms_decibel_level_alarm.
`default_nettype none

module rdla_checker import rdla_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   in_valid,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input level_t level_db,
  input logic   alarm,
  input logic   silent
);

  // A stalled result keeps its value until the transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(level_db) && $stable(alarm) &&
      $stable(silent))
    else $error("result changed while stalled");

  // A result never appears in the cycle right after a sample transfer.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared without a level computation");

  // A silent block reports the floor level.
  a_silent_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid && silent |-> level_db == -8'sd64)
    else $error("silent block not at floor level");

  // Reported levels stay within the saturation range.
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $signed(level_db) >= -8'sd64 && $signed(level_db) <= 8'sd80)
    else $error("level outside saturation range");

endmodule

bind rms_decibel_level_alarm rdla_checker u_rdla_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (audio.valid),
  .in_ready  (audio.ready),
  .out_valid (level.valid),
  .out_ready (level.ready),
  .level_db  (level.level_db),
  .alarm     (level.alarm),
  .silent    (level.silent)
);

`default_nettype wire

[test/tb_top.sv]
// Testbench for the RMS decibel level alarm: drives audio samples and APB register
// writes, predicts every block level and checks each level transfer against it.
// Depends on rdla_pkg, rdla_sample_if, rdla_level_if and rms_decibel_level_alarm.

module tb_top;
  import rdla_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Level limits and scaling used by the prediction.
  localparam int          FLOOR_DB  = -64;
  localparam int          CEIL_DB   = 80;
  localparam logic [63:0] FULL_SQ   = 64'd1073676289;
  localparam logic [63:0] DEC_SCALE = 64'd1000000000;

  // Samples sent in the random phases.
  localparam int RANDOM_ITEMS = 1100;

  // Predicts block levels from accepted samples and checks level transfers.
  class level_scoreboard;
    typedef struct packed {
      level_t level_db;
      logic   alarm;
      logic   silent;
    } level_rec_t;

    logic [15:0] block_len;
    logic [6:0]  offset;
    level_t      upper;
    level_t      lower;
    logic [46:0] energy;
    logic [15:0] count;
    logic [32:0] decade_coef [10];
    level_rec_t  pending [$];
    int          mismatches;

    function new();
      block_len  = 16'd9600;
      offset     = 7'd72;
      upper      = 8'sd60;
      lower      = 8'sd0;
      energy     = '0;
      count      = '0;
      mismatches = 0;
      // 10^(r/10) scaled by 10^9, rounded to nearest.
      decade_coef = '{33'd1000000000, 33'd1258925412, 33'd1584893192, 33'd1995262315,
                      33'd2511886432, 33'd3162277660, 33'd3981071706, 33'd5011872336,
                      33'd6309573445, 33'd7943282347};
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH at %0t: %s", $time, msg);
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_BLOCK_LENGTH:    block_len = val[15:0];
        REG_LEVEL_OFFSET:    offset = val[6:0];
        REG_UPPER_THRESHOLD: upper = val[7:0];
        REG_LOWER_THRESHOLD: lower = val[7:0];
        default: ;
      endcase
    endfunction

    function void check_reg(reg_idx_t idx, logic [31:0] got);
      logic [31:0] want;
      logic [31:0] mask;
      case (idx)
        REG_BLOCK_LENGTH: begin
          want = {16'b0, block_len};
          mask = 32'h0000_FFFF;
        end
        REG_LEVEL_OFFSET: begin
          want = {25'b0, offset};
          mask = 32'h0000_007F;
        end
        REG_UPPER_THRESHOLD: begin
          want = {24'b0, upper};
          mask = 32'h0000_00FF;
        end
        default: begin
          want = {24'b0, lower};
          mask = 32'h0000_00FF;
        end
      endcase
      if ((got & mask) !== (want & mask))
        report($sformatf("register %s read expected %0h got %0h",
                         idx.name(), want & mask, got & mask));
    endfunction

    // Accumulates one sample; at the end of a block, works out its level.
    function void note_sample(sample_t smp);
      logic [16:0]  mag;
      logic [16:0]  len;
      logic [16:0]  cnt;
      logic [63:0]  pwr;
      logic [191:0] lhs;
      logic [191:0] rhs;
      int           d;
      int           m;
      int           q;
      int           r;
      int           off;
      logic         quiet;
      level_rec_t   rec;
      mag = smp[15] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
      energy = energy + 47'(mag) * 47'(mag);
      len = (block_len == 16'd0) ? 17'd1 : {1'b0, block_len};
      cnt = {1'b0, count} + 17'd1;
      if (cnt < len) begin
        count = cnt[15:0];
        return;
      end
      pwr = 64'(cnt) * FULL_SQ;
      off = int'(offset);
      quiet = 1'b0;
      if (energy == 47'd0) begin
        d = FLOOR_DB;
        quiet = 1'b1;
      end else if (64'(energy) > pwr) begin
        // Above full scale: less than one dB over it.
        d = off + 1;
      end else begin
        // Walk down in tenths of a decade while the mean square still fits.
        rhs = 192'(pwr) * 192'(DEC_SCALE);
        m = 0;
        while (off - m > FLOOR_DB) begin
          q = (m + 1) / 10;
          r = (m + 1) % 10;
          lhs = 192'(energy) * 192'(decade_coef[r]);
          repeat (q) lhs = lhs * 192'd10;
          if (lhs > rhs) break;
          m++;
        end
        d = off - m;
      end
      if (d > CEIL_DB) d = CEIL_DB;
      if (d < FLOOR_DB) d = FLOOR_DB;
      rec.level_db = level_t'(d);
      rec.alarm = (d >= int'(upper)) || (d <= int'(lower));
      rec.silent = quiet;
      pending.push_back(rec);
      energy = '0;
      count = '0;
    endfunction

    // Compares one level transfer with the oldest predicted level.
    function void check_level(level_t lvl, logic alm, logic sil);
      level_rec_t want;
      if (pending.size() == 0) begin
        report($sformatf("level %0d alarm %b silent %b with no block pending",
                         $signed(lvl), alm, sil));
        return;
      end
      want = pending.pop_front();
      if (lvl !== want.level_db || alm !== want.alarm || sil !== want.silent)
        report($sformatf("level/alarm/silent expected %0d/%b/%b got %0d/%b/%b",
                         $signed(want.level_db), want.alarm, want.silent,
                         $signed(lvl), alm, sil));
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  rdla_sample_if audio_if ();
  rdla_level_if  level_if ();

  level_scoreboard sb = new();
  bit              burst;

  rms_decibel_level_alarm dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .audio   (audio_if),
    .level   (level_if)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watch both channels; samples are noted before levels are checked.
  always @(posedge clk) begin
    if (rst === 1'b0) begin
      if (audio_if.valid && audio_if.ready) sb.note_sample(audio_if.sample);
      if (level_if.valid && level_if.ready)
        sb.check_level(level_if.level_db, level_if.alarm, level_if.silent);
    end
  end

  // Level receiver: stalls a random number of cycles before each transfer.
  initial begin
    int stall;
    level_if.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 13));
      if (stall > 0) begin
        level_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      level_if.ready <= 1'b1;
      do @(posedge clk); while (!level_if.valid);
    end
  end

  // One sample transfer, after a random gap unless the phase runs in bursts.
  task automatic send_sample(input sample_t val);
    int gap;
    gap = (burst || $urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 13));
    if (gap > 0) begin
      audio_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    audio_if.valid  <= 1'b1;
    audio_if.sample <= val;
    do @(posedge clk); while (!audio_if.ready);
  endtask

  // Stop sending and wait until every predicted level has been transferred.
  task automatic wait_for_results();
    audio_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_read(input reg_idx_t idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.check_reg(idx, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes all four registers once the block is idle, then reads them back.
  task automatic apply_settings(input int blen, input int off, input int up, input int lo);
    logic [31:0] vals [4];
    vals[0] = 32'(blen);
    vals[1] = 32'(off);
    vals[2] = 32'(up);
    vals[3] = 32'(lo);
    wait_for_results();
    for (int i = 0; i < 4; i++) reg_write(reg_idx_t'(i), vals[i]);
    for (int i = 0; i < 4; i++) reg_read(reg_idx_t'(i));
  endtask

  initial begin
    sample_t smp;
    int      blen;
    int      off;
    int      up;
    int      lo;
    int      kind;
    int      shift;
    int      n;
    int      nblk;
    int      random_items;
    bit      paused;
    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    audio_if.valid  <= 1'b0;
    audio_if.sample <= '0;
    burst = 1'b0;
    random_items = 0;
    paused = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values: read back, then a short block at the reset offset and
    // thresholds, ended by lowering the block length part way through.
    for (int i = 0; i < 4; i++) reg_read(reg_idx_t'(i));
    burst = 1'b1;
    for (int i = 0; i < 19; i++) send_sample(sample_t'($urandom));
    burst = 1'b0;
    wait_for_results();
    reg_write(REG_BLOCK_LENGTH, 32'd20);
    send_sample(sample_t'($urandom) >>> 4);

    // Single-sample blocks: silence, exact full scale, above full scale, tiny and mid-range values.
    apply_settings(1, 72, 60, 0);
    send_sample(16'sd0);
    send_sample(16'sd32767);
    send_sample(16'sh8000);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sd12345);
    send_sample(-16'sd23170);

    // Zero block length acts as one; the top offset saturates at the ceiling.
    apply_settings(0, 127, 80, -64);
    send_sample(16'sh8000);
    send_sample(16'sd32767);
    send_sample(16'sd1);
    send_sample(16'sd0);

    // Zero offset: a quiet block stops at the floor; thresholds out of range.
    apply_settings(4, 0, 127, -128);
    repeat (4) send_sample(16'sd0);
    send_sample(16'sd3);
    send_sample(-16'sd3);
    send_sample(16'sd2);
    send_sample(-16'sd1);

    // Block length lowered below the samples already summed in a block.
    apply_settings(6, 40, -128, -128);
    send_sample(16'sd16384);
    send_sample(-16'sd16384);
    send_sample(16'sd100);
    apply_settings(2, 40, -128, -128);
    send_sample(-16'sd200);

    // Long block at full negative scale: just above full scale, so no search.
    apply_settings(256, 72, 60, 0);
    burst = 1'b1;
    for (int i = 0; i < 256; i++) send_sample(16'sh8000);

    // Random phases: new settings, then a few blocks of random loudness.
    while (random_items < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) blen = 0;
      else if (kind == 1) blen = 1;
      else if (kind <= 6) blen = $urandom_range(2, 24);
      else if (kind <= 8) blen = $urandom_range(25, 200);
      else blen = $urandom_range(201, 600);
      if ($urandom_range(0, 5) == 0) off = ($urandom_range(0, 1) == 1) ? 127 : 0;
      else off = $urandom_range(0, 127);
      if ($urandom_range(0, 5) == 0) up = int'($signed(8'($urandom)));
      else up = int'($urandom_range(0, 144)) - 64;
      if ($urandom_range(0, 5) == 0) lo = int'($signed(8'($urandom)));
      else lo = int'($urandom_range(0, 144)) - 64;
      apply_settings(blen, off, up, lo);
      burst = ($urandom_range(0, 3) == 0);
      nblk = $urandom_range(1, 5);
      for (int b = 0; b < nblk; b++) begin
        kind = $urandom_range(0, 9);
        shift = $urandom_range(0, 15);
        n = (blen == 0) ? 1 : blen;
        // Sometimes leave a block partly filled for the next settings.
        if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
        for (int i = 0; i < n && random_items < RANDOM_ITEMS; i++) begin
          if (kind == 0) smp = 16'sd0;
          else if (kind == 1) begin
            case ($urandom_range(0, 2))
              0:       smp = 16'sd32767;
              1:       smp = 16'sh8000;
              default: smp = -16'sd32767;
            endcase
          end else smp = sample_t'($urandom) >>> shift;
          send_sample(smp);
          random_items++;
        end
        // Hold the samples back until all levels are out, at least once.
        if (!paused || $urandom_range(0, 9) == 0) begin
          wait_for_results();
          paused = 1'b1;
        end
      end
    end

    wait_for_results();
    repeat (600) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #80_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
